// ===== design/double_ended_queue_defines.svh =====
// ============================================================================
// double_ended_queue_defines.svh
// Assertion macros used by the double-ended queue design.
// ============================================================================
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define DEQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque check failed");

// Check that a condition implies a consequence in the next cycle.
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque check failed");

`endif

// ===== design/deq_pkg.sv =====
// ============================================================================
// deq_pkg
// Types and codes shared by the double-ended queue files.
// ============================================================================
package deq_pkg;

    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 32;

    // Request action codes; the remaining codes are accepted and answered OK with no other effect
    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_LIST       = 3'd4
    } t_action;

    // Response status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Control sequencer states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_LIST = 1'b1
    } t_state;

endpackage

// ===== design/deq_if.sv =====
// ============================================================================
// deq_if
// Valid/ready channels for deque requests and responses.
// ============================================================================
interface deq_req_if;
    import deq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic signed [DATA_W-1:0]   value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface deq_rsp_if;
    import deq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic signed [DATA_W-1:0]   data;
    logic                       last;

    modport source (output valid, output status, output data, output last, input ready);
    modport sink   (input valid, input status, input data, input last, output ready);
endinterface

// ===== design/double_ended_queue.sv =====
// ============================================================================
// double_ended_queue
// Double-ended queue of signed 32-bit values held in a RAM ring.
// ============================================================================
// Usage:
//   i_req carries an action (push front, push back, pop front, pop back,
//   list) and a value; o_rsp returns status, data and a last flag.
//   Push and pop: one response per request, registered in the cycle after the
//   transfer; a new request is taken every cycle while o_rsp drains.
//   A full push reports full and changes nothing; a pop on an empty queue
//   reports empty.
//   List: the request is taken, then the entries are read front to back
//   from the RAM and leave one per cycle while o_rsp drains; the first
//   entry passes the read address, RAM read data and output registers.
//   last marks the final entry. No request is taken until the final entry
//   is in the output register. A list on an empty queue gives one empty
//   response. The rate is set by the single RAM read port and its
//   registered read data. When o_rsp stalls, the output register holds its
//   response, the RAM read data holds the next entry and no new request is
//   taken. Reset empties the queue; stored values stay undefined until pushed.
// ============================================================================
`include "double_ended_queue_defines.svh"

module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    deq_req_if.sink     i_req,
    deq_rsp_if.source   o_rsp
);
    import deq_pkg::*;

    localparam int IdxW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    t_state                   r_state, n_state;
    logic [IdxW-1:0]          r_front, n_front;
    logic [IdxW-1:0]          r_back, n_back;
    logic [CntW-1:0]          r_count, n_count;
    logic [IdxW-1:0]          r_pos, n_pos;
    logic [CntW-1:0]          r_left, n_left;
    logic                     r_pend, n_pend;
    logic                     r_pend_last, n_pend_last;
    logic                     r_out_valid, n_out_valid;
    t_status                  r_out_status, n_out_status;
    logic signed [DATA_W-1:0] r_out_data, n_out_data;
    logic                     r_out_last, n_out_last;

    logic                     out_free;
    logic                     in_ready;
    logic                     req_xfer;
    logic                     ram_we;
    logic [IdxW-1:0]          ram_waddr;
    logic                     ram_re;
    logic [DATA_W-1:0]        ram_rdata;

    function automatic logic [IdxW-1:0] idx_next(input logic [IdxW-1:0] idx);
        return (idx == LastIdx) ? '0 : idx + IdxW'(1);
    endfunction

    function automatic logic [IdxW-1:0] idx_prev(input logic [IdxW-1:0] idx);
        return (idx == '0) ? LastIdx : idx - IdxW'(1);
    endfunction

    // Entry storage
    deq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_req.value),
        .i_re    (ram_re),
        .i_raddr (r_pos),
        .o_rdata (ram_rdata)
    );

    // Handshake
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign in_ready    = (r_state == S_IDLE) && out_free;
    assign req_xfer    = i_req.valid && in_ready;
    assign i_req.ready = in_ready;

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_out_status;
    assign o_rsp.data   = r_out_data;
    assign o_rsp.last   = r_out_last;

    // Next state, ring update and response selection
    always_comb begin
        n_state      = r_state;
        n_front      = r_front;
        n_back       = r_back;
        n_count      = r_count;
        n_pos        = r_pos;
        n_left       = r_left;
        n_pend       = r_pend;
        n_pend_last  = r_pend_last;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;
        n_out_last   = r_out_last;
        ram_we       = 1'b0;
        ram_waddr    = r_back;
        ram_re       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (req_xfer) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_data   = '0;
                    n_out_last   = 1'b1;
                    case (i_req.action)
                        ACT_PUSH_FRONT: begin
                            if (r_count == FullCnt) begin
                                n_out_status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = idx_prev(r_front);
                                n_front   = idx_prev(r_front);
                                n_count   = r_count + CntW'(1);
                            end
                        end
                        ACT_PUSH_BACK: begin
                            if (r_count == FullCnt) begin
                                n_out_status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_back;
                                n_back    = idx_next(r_back);
                                n_count   = r_count + CntW'(1);
                            end
                        end
                        ACT_POP_FRONT: begin
                            if (r_count == '0) begin
                                n_out_status = ST_EMPTY;
                            end else begin
                                n_front = idx_next(r_front);
                                n_count = r_count - CntW'(1);
                            end
                        end
                        ACT_POP_BACK: begin
                            if (r_count == '0) begin
                                n_out_status = ST_EMPTY;
                            end else begin
                                n_back  = idx_prev(r_back);
                                n_count = r_count - CntW'(1);
                            end
                        end
                        ACT_LIST: begin
                            if (r_count == '0) begin
                                n_out_status = ST_EMPTY;
                            end else begin
                                // No response yet: the entries follow from the RAM
                                n_out_valid = r_out_valid && !o_rsp.ready;
                                n_state     = S_LIST;
                                n_pos       = r_front;
                                n_left      = r_count;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LIST: begin
                // Move the pending entry into the output register
                if (r_pend && out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_data   = $signed(ram_rdata);
                    n_out_last   = r_pend_last;
                    n_pend       = 1'b0;
                    if (r_pend_last) begin
                        n_state = S_IDLE;
                    end
                end
                // Issue the next read once the RAM data register is free
                if ((r_left != '0) && (!r_pend || out_free)) begin
                    ram_re      = 1'b1;
                    n_pos       = idx_next(r_pos);
                    n_left      = r_left - CntW'(1);
                    n_pend      = 1'b1;
                    n_pend_last = (r_left == CntW'(1));
                end
            end
            default: ;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_back      <= '0;
            r_count     <= '0;
            r_left      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_back      <= n_back;
            r_count     <= n_count;
            r_left      <= n_left;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_pend_last  <= n_pend_last;
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
        r_out_last   <= n_out_last;
    end

    // Occupancy never exceeds the ring size
    `DEQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FullCnt)
    // Occupancy holds while a listing streams
    `DEQ_ASSERT_NEXT(a_list_count_stable, i_clk, i_rst_n, r_state == S_LIST, $stable(r_count))
    // A pending RAM read belongs to a listing
    `DEQ_ASSERT_NOW(a_pend_in_list, i_clk, i_rst_n, r_pend, r_state == S_LIST)
    // No write lands in the RAM during a listing
    `DEQ_ASSERT_NOW(a_no_write_in_list, i_clk, i_rst_n, r_state == S_LIST, !ram_we)
endmodule

// ===== design/deq_ram.sv =====
// ============================================================================
// deq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write on enable; read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
